// File: sv/tde_pkg.sv
// Shared types, constants and the symbol decoder of the trie dictionary engine.
package tde_pkg;

	localparam int NODE_COUNT = 2048;
	localparam int SLOTS      = 37;
	localparam int TERM_SLOT  = 36;
	localparam int DIGIT_BASE = 26;

	localparam int NODE_W  = $clog2(NODE_COUNT);
	localparam int ID_W    = 11;
	localparam int ENTRY_W = (NODE_W > ID_W) ? NODE_W : ID_W;
	localparam int DEPTH   = NODE_COUNT * SLOTS;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int SLOT_W  = $clog2(SLOTS);

	localparam logic [7:0] SYM_LOWER_A = 8'h61;
	localparam logic [7:0] SYM_LOWER_Z = 8'h7A;
	localparam logic [7:0] SYM_UPPER_A = 8'h41;
	localparam logic [7:0] SYM_UPPER_Z = 8'h5A;
	localparam logic [7:0] SYM_DIGIT_0 = 8'h30;
	localparam logic [7:0] SYM_DIGIT_9 = 8'h39;
	localparam logic [7:0] SYM_TERM    = 8'h23;

	typedef enum logic [1:0] {
		RES_NEW       = 2'd0,
		RES_PRESENT   = 2'd1,
		RES_NOT_FOUND = 2'd2,
		RES_FULL      = 2'd3
	} res_status_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] idx;
	} slot_t;

	typedef struct packed {
		logic clr_step;
		logic capture;
		logic decide;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic term_pending;
		logic out_blocked;
	} dp_stat_t;

	function automatic slot_t slot_of(logic [7:0] sym);
		slot_t r;
		r.ok  = 1'b1;
		r.idx = '0;
		case (sym) inside
			[SYM_LOWER_A:SYM_LOWER_Z]: begin
				r.idx = SLOT_W'(sym - SYM_LOWER_A);
			end
			[SYM_UPPER_A:SYM_UPPER_Z]: begin
				r.idx = SLOT_W'(sym - SYM_UPPER_A);
			end
			[SYM_DIGIT_0:SYM_DIGIT_9]: begin
				r.idx = SLOT_W'(sym - SYM_DIGIT_0) + SLOT_W'(DIGIT_BASE);
			end
			SYM_TERM: begin
				r.idx = SLOT_W'(TERM_SLOT);
			end
			default: begin
				r.ok = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage

// File: sv/tde_ctrl.sv
// Controller state machine of the trie dictionary engine.
module tde_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tde_pkg::dp_stat_t stat,
	output tde_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd.clr_step = 1'b0;
		cmd.capture  = 1'b0;
		cmd.decide   = 1'b0;
		in_ready     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				// A terminator waits until the output register can take its result.
				if (!(stat.term_pending && stat.out_blocked)) begin
					cmd.decide = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/tde_datapath.sv
// Datapath of the trie dictionary engine: edge table, walk state, counters and result register.
module tde_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tde_pkg::dp_cmd_t          cmd,
	input  logic                      mode,
	input  logic [7:0]                symbol,
	input  logic                      out_ready,
	output tde_pkg::dp_stat_t         stat,
	output logic                      out_valid,
	output logic [tde_pkg::ID_W-1:0]  string_id,
	output logic [1:0]                status
);

	logic [tde_pkg::ENTRY_W-1:0] mem [tde_pkg::DEPTH];

	logic [tde_pkg::ADDR_W-1:0]  clr_addr_q;
	logic [tde_pkg::NODE_W-1:0]  cur_node_q, nodes_used_q;
	logic [tde_pkg::ID_W-1:0]    next_id_q;
	logic                        walk_failed_q;

	logic                        mode_s1;
	tde_pkg::slot_t              slot_s1;
	logic [tde_pkg::ADDR_W-1:0]  addr_s1;
	logic [tde_pkg::ENTRY_W-1:0] rdata_q;

	logic                        out_valid_q;
	logic [tde_pkg::ID_W-1:0]    string_id_q;
	tde_pkg::res_status_t        status_q;

	tde_pkg::slot_t              slot_in;
	logic [tde_pkg::ADDR_W-1:0]  rd_addr;

	logic                        upd_wr;
	logic [tde_pkg::ENTRY_W-1:0] upd_data;
	logic [tde_pkg::NODE_W-1:0]  cur_node_d, nodes_used_d, nodes_inc;
	logic [tde_pkg::ID_W-1:0]    next_id_d, held_id;
	logic                        walk_failed_d;
	logic                        push;
	logic [tde_pkg::ID_W-1:0]    res_id;
	tde_pkg::res_status_t        res_status;

	logic                        mem_wr;
	logic [tde_pkg::ADDR_W-1:0]  mem_waddr;
	logic [tde_pkg::ENTRY_W-1:0] mem_wdata;

	assign slot_in = tde_pkg::slot_of(symbol);
	assign rd_addr = tde_pkg::ADDR_W'(tde_pkg::ADDR_W'(cur_node_q)
			* tde_pkg::ADDR_W'(tde_pkg::SLOTS)) + tde_pkg::ADDR_W'(slot_in.idx);

	assign nodes_inc = nodes_used_q + tde_pkg::NODE_W'(1);
	assign held_id   = rdata_q[tde_pkg::ID_W-1:0];

	always_comb begin
		upd_wr        = 1'b0;
		upd_data      = '0;
		cur_node_d    = cur_node_q;
		nodes_used_d  = nodes_used_q;
		next_id_d     = next_id_q;
		walk_failed_d = walk_failed_q;
		push          = 1'b0;
		res_id        = '0;
		res_status    = tde_pkg::RES_NEW;
		if (!slot_s1.ok) begin
			cur_node_d = '0;
		end else if (slot_s1.idx != tde_pkg::SLOT_W'(tde_pkg::TERM_SLOT)) begin
			if (!walk_failed_q) begin
				if (rdata_q != '0) begin
					cur_node_d = rdata_q[tde_pkg::NODE_W-1:0];
				end else if (mode_s1) begin
					walk_failed_d = 1'b1;
				end else if (nodes_used_q != tde_pkg::NODE_W'(tde_pkg::NODE_COUNT - 1)) begin
					nodes_used_d = nodes_inc;
					cur_node_d   = nodes_inc;
					upd_wr       = 1'b1;
					upd_data     = tde_pkg::ENTRY_W'(nodes_inc);
				end else begin
					walk_failed_d = 1'b1;
				end
			end
		end else begin
			push          = 1'b1;
			cur_node_d    = '0;
			walk_failed_d = 1'b0;
			if (mode_s1) begin
				if (walk_failed_q || rdata_q == '0) begin
					res_status = tde_pkg::RES_NOT_FOUND;
				end else begin
					res_id     = held_id;
					res_status = tde_pkg::RES_PRESENT;
				end
			end else if (walk_failed_q) begin
				res_status = tde_pkg::RES_FULL;
			end else if (rdata_q != '0) begin
				res_id     = held_id;
				res_status = tde_pkg::RES_PRESENT;
			end else if (next_id_q == '0) begin
				res_status = tde_pkg::RES_FULL;
			end else begin
				res_id    = next_id_q;
				upd_wr    = 1'b1;
				upd_data  = tde_pkg::ENTRY_W'(next_id_q);
				next_id_d = next_id_q + tde_pkg::ID_W'(1);
			end
		end
	end

	assign mem_wr    = cmd.clr_step || (cmd.decide && upd_wr);
	assign mem_waddr = cmd.clr_step ? clr_addr_q : addr_s1;
	assign mem_wdata = cmd.clr_step ? '0 : upd_data;

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.capture) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_s1 <= mode;
			slot_s1 <= slot_in;
			addr_s1 <= rd_addr;
		end
		if (cmd.decide && push) begin
			string_id_q <= res_id;
			status_q    <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q    <= '0;
			cur_node_q    <= '0;
			nodes_used_q  <= '0;
			next_id_q     <= tde_pkg::ID_W'(1);
			walk_failed_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + tde_pkg::ADDR_W'(1);
			end
			if (cmd.decide) begin
				cur_node_q    <= cur_node_d;
				nodes_used_q  <= nodes_used_d;
				next_id_q     <= next_id_d;
				walk_failed_q <= walk_failed_d;
			end
			// A new result may replace one that is taken in the same cycle.
			if (cmd.decide && push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.clr_last     = clr_addr_q == tde_pkg::ADDR_W'(tde_pkg::DEPTH - 1);
	assign stat.term_pending = slot_s1.ok && slot_s1.idx == tde_pkg::SLOT_W'(tde_pkg::TERM_SLOT);
	assign stat.out_blocked  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign string_id = string_id_q;
	assign status    = status_q;

endmodule

// File: sv/trie_dictionary_engine_top.sv
// Top level of the trie dictionary engine: controller, datapath and assertions.
//
//  Channel   Signals                          Direction  Meaning
//  input     in_valid, in_ready, mode, symbol  in         one character of a string per item
//  output    out_valid, out_ready, string_id,  out        one result item per terminator '#'
//            status
//
// Each input item is handled in two steps: one to read its entry of the edge table, one to
// decide, write back the same entry if a node or id is allocated, and update the walk.
// After reset the edge table is cleared one entry per cycle, 75776 entries at the default
// node count, and no item is accepted during that pass.
// A result item waits in an output register; only a terminator that finds that register
// still occupied holds the block until the result there is taken.
module trie_dictionary_engine_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic [7:0]                symbol,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [tde_pkg::ID_W-1:0]  string_id,
	output logic [1:0]                status
);

	tde_pkg::dp_cmd_t  cmd;
	tde_pkg::dp_stat_t stat;

	// The controller sequences the clearing pass and the two steps of each item.
	tde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the edge table, the walk state and the result register.
	tde_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mode      (mode),
		.symbol    (symbol),
		.out_ready (out_ready),
		.stat      (stat),
		.out_valid (out_valid),
		.string_id (string_id),
		.status    (status)
	);

`ifndef SYNTH
	// No item is accepted while the table is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_step && in_ready))
		else $error("input ready during clearing pass");

	// An accepted item is always followed by its decision cycle.
	a_two_cycle_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready && !cmd.capture))
		else $error("item accepted back to back");

	// A result is never pushed over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && stat.term_pending) |-> !(out_valid && !out_ready))
		else $error("result register overwritten");
`endif

endmodule
